[rtl/mcw_pkg.sv]
package mcw_pkg;

  localparam int unsigned MaxText    = 4096;
  localparam int unsigned MaxPattern = 256;
  localparam int unsigned SymW       = 8;
  localparam int unsigned NumSym     = 1 << SymW;
  localparam int unsigned TextAw     = $clog2(MaxText);
  localparam int unsigned PosW       = TextAw + 1;
  localparam int unsigned NeedW      = $clog2(MaxPattern + 1);
  localparam int unsigned WinW       = PosW;
  localparam int unsigned KindW      = SymW + 1;

  typedef enum logic [1:0] {
    CmdClear   = 2'd0,
    CmdPattern = 2'd1,
    CmdText    = 2'd2,
    CmdFinish  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StPatRd,
    StTxtRd,
    StCheck,
    StLeftTxt,
    StLeftCnt
  } state_e;

  typedef struct packed {
    logic [NeedW-1:0] need;
    logic [WinW-1:0]  win;
  } cnt_entry_t;

  typedef struct packed {
    logic            rd;
    logic            wr;
    logic            clr;
    logic [SymW-1:0] addr;
    cnt_entry_t      wdata;
  } cnt_req_t;

endpackage

[rtl/mcw_if.sv]
interface mcw_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [mcw_pkg::SymW-1:0] symbol;

  modport source (output valid, output cmd, output symbol, input ready);
  modport sink (input valid, input cmd, input symbol, output ready);
endinterface

interface mcw_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [mcw_pkg::TextAw-1:0] window_start;
  logic [mcw_pkg::PosW-1:0]   window_length;
  logic                       truncated;

  modport source (output valid, output found, output window_start, output window_length,
                  output truncated, input ready);
  modport sink (input valid, input found, input window_start, input window_length,
                input truncated, output ready);
endinterface

[rtl/minimum_covering_window_finder_top.sv]
// Minimum covering window finder. Send clear, then the pattern bytes, then the text bytes;
// a finish beat returns found, the start and length of the shortest text window that holds
// every pattern byte with its multiplicity (earliest wins a tie), and a flag that bytes beyond
// 256 pattern or 4096 text positions were dropped. Only finish produces a result beat. Items
// are handled one at a time. Clear, finish and an ignored or dropped byte need no memory
// read; a pattern byte reads its count entry and writes it back; a text byte is stored, its
// entry is read and written back, and each left shrink step it triggers reads the text store
// and then the count memory. In total the left edge moves no further than the text bytes
// taken. No beat is taken while a report waits unaccepted. Counts clear at once on clear; no
// clearing pass follows reset.
module minimum_covering_window_finder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcw_in_if.sink    req_i,
  mcw_out_if.source rsp_o
);

  localparam int unsigned TextAw = mcw_pkg::TextAw;
  localparam int unsigned PosW   = mcw_pkg::PosW;
  localparam int unsigned KindW  = mcw_pkg::KindW;
  localparam int unsigned NeedW  = mcw_pkg::NeedW;
  localparam int unsigned WinW   = mcw_pkg::WinW;
  localparam int unsigned SymW   = mcw_pkg::SymW;

  mcw_pkg::state_e      state_q, state_d;
  logic [PosW-1:0]      left_q, left_d, right_q, right_d;
  logic [KindW-1:0]     covered_q, covered_d, needed_q, needed_d;
  logic [NeedW-1:0]     plen_q, plen_d;
  logic [TextAw-1:0]    best_start_q, best_start_d;
  logic [PosW-1:0]      best_len_q, best_len_d;
  logic                 ovf_q, ovf_d;
  logic [SymW-1:0]      sym_q, sym_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q, out_found_d;
  logic [TextAw-1:0]    out_start_q, out_start_d;
  logic [PosW-1:0]      out_len_q, out_len_d;
  logic                 out_trunc_q, out_trunc_d;

  mcw_pkg::cnt_req_t    cnt_req;
  mcw_pkg::cnt_entry_t  cnt_rdata;
  logic                 txt_wr, txt_rd;
  logic [SymW-1:0]      txt_rdata;

  logic                 accept;
  logic                 pat_ok, txt_ok, shrink;
  logic [WinW-1:0]      win_inc, win_dec;
  logic [PosW-1:0]      cur_len;

  assign req_i.ready = (state_q == mcw_pkg::StIdle) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign pat_ok  = (right_q == '0) && (plen_q < NeedW'(mcw_pkg::MaxPattern));
  assign txt_ok  = right_q < PosW'(mcw_pkg::MaxText);
  assign shrink  = (needed_q != '0) && (covered_q == needed_q) && (left_q < right_q);
  assign win_inc = cnt_rdata.win + 1'b1;
  assign win_dec = cnt_rdata.win - 1'b1;
  assign cur_len = right_q - left_q;

  mcw_count_mem u_count_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cnt_req),
    .rdata_o (cnt_rdata)
  );

  mcw_text_mem u_text_mem (
    .clk_i   (clk_i),
    .wr_i    (txt_wr),
    .waddr_i (right_q[TextAw-1:0]),
    .wdata_i (req_i.symbol),
    .rd_i    (txt_rd),
    .raddr_i (left_q[TextAw-1:0]),
    .rdata_o (txt_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcw_pkg::StIdle: begin
        if (accept) begin
          if (req_i.cmd == mcw_pkg::CmdPattern && pat_ok) begin
            state_d = mcw_pkg::StPatRd;
          end else if (req_i.cmd == mcw_pkg::CmdText && txt_ok) begin
            state_d = mcw_pkg::StTxtRd;
          end
        end
      end
      mcw_pkg::StPatRd:   state_d = mcw_pkg::StIdle;
      mcw_pkg::StTxtRd:   state_d = mcw_pkg::StCheck;
      mcw_pkg::StCheck:   state_d = shrink ? mcw_pkg::StLeftTxt : mcw_pkg::StIdle;
      mcw_pkg::StLeftTxt: state_d = mcw_pkg::StLeftCnt;
      mcw_pkg::StLeftCnt: state_d = mcw_pkg::StCheck;
      default:            state_d = mcw_pkg::StIdle;
    endcase
  end

  // memory requests
  always_comb begin
    cnt_req       = '0;
    cnt_req.addr  = sym_q;
    cnt_req.wdata = cnt_rdata;
    txt_wr        = 1'b0;
    txt_rd        = 1'b0;
    unique case (state_q)
      mcw_pkg::StIdle: begin
        cnt_req.addr = req_i.symbol;
        if (accept) begin
          if (req_i.cmd == mcw_pkg::CmdClear) begin
            cnt_req.clr = 1'b1;
          end else if (req_i.cmd == mcw_pkg::CmdPattern) begin
            cnt_req.rd = pat_ok;
          end else if (req_i.cmd == mcw_pkg::CmdText) begin
            cnt_req.rd = txt_ok;
            txt_wr     = txt_ok;
          end
        end
      end
      mcw_pkg::StPatRd: begin
        cnt_req.wr         = 1'b1;
        cnt_req.wdata.need = cnt_rdata.need + 1'b1;
      end
      mcw_pkg::StTxtRd: begin
        cnt_req.wr        = cnt_rdata.need != '0;
        cnt_req.wdata.win = win_inc;
      end
      mcw_pkg::StCheck: begin
        txt_rd = shrink;
      end
      mcw_pkg::StLeftTxt: begin
        cnt_req.rd   = 1'b1;
        cnt_req.addr = txt_rdata;
      end
      mcw_pkg::StLeftCnt: begin
        cnt_req.wr        = cnt_rdata.need != '0;
        cnt_req.wdata.win = win_dec;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    left_d       = left_q;
    right_d      = right_q;
    covered_d    = covered_q;
    needed_d     = needed_q;
    plen_d       = plen_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    ovf_d        = ovf_q;
    sym_d        = sym_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_found_d  = out_found_q;
    out_start_d  = out_start_q;
    out_len_d    = out_len_q;
    out_trunc_d  = out_trunc_q;
    unique case (state_q)
      mcw_pkg::StIdle: begin
        if (accept) begin
          unique case (req_i.cmd)
            mcw_pkg::CmdClear: begin
              left_d       = '0;
              right_d      = '0;
              covered_d    = '0;
              needed_d     = '0;
              plen_d       = '0;
              best_start_d = '0;
              best_len_d   = '0;
              ovf_d        = 1'b0;
            end
            mcw_pkg::CmdPattern: begin
              sym_d = req_i.symbol;
              if (right_q == '0) begin
                if (pat_ok) begin
                  plen_d = plen_q + 1'b1;
                end else begin
                  ovf_d = 1'b1;
                end
              end
            end
            mcw_pkg::CmdText: begin
              sym_d = req_i.symbol;
              if (txt_ok) begin
                right_d = right_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              out_found_d = best_len_q != '0;
              out_start_d = (best_len_q != '0) ? best_start_q : '0;
              out_len_d   = best_len_q;
              out_trunc_d = ovf_q;
            end
          endcase
        end
      end
      mcw_pkg::StPatRd: begin
        if (cnt_rdata.need == '0) begin
          needed_d = needed_q + 1'b1;
        end
      end
      mcw_pkg::StTxtRd: begin
        if (cnt_rdata.need != '0 && win_inc == WinW'(cnt_rdata.need)) begin
          covered_d = covered_q + 1'b1;
        end
      end
      mcw_pkg::StCheck: begin
        if (shrink && (best_len_q == '0 || cur_len < best_len_q)) begin
          best_start_d = left_q[TextAw-1:0];
          best_len_d   = cur_len;
        end
      end
      mcw_pkg::StLeftTxt: begin
        sym_d = txt_rdata;
      end
      mcw_pkg::StLeftCnt: begin
        left_d = left_q + 1'b1;
        if (cnt_rdata.need != '0 && win_dec < WinW'(cnt_rdata.need)) begin
          covered_d = covered_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mcw_pkg::StIdle;
      left_q       <= '0;
      right_q      <= '0;
      covered_q    <= '0;
      needed_q     <= '0;
      plen_q       <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      left_q       <= left_d;
      right_q      <= right_d;
      covered_q    <= covered_d;
      needed_q     <= needed_d;
      plen_q       <= plen_d;
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    out_found_q <= out_found_d;
    out_start_q <= out_start_d;
    out_len_q   <= out_len_d;
    out_trunc_q <= out_trunc_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.found         = out_found_q;
  assign rsp_o.window_start  = out_start_q;
  assign rsp_o.window_length = out_len_q;
  assign rsp_o.truncated     = out_trunc_q;

`ifndef NO_ASSERTIONS
  a_left_le_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= right_q) else $error("left edge passed right edge");
  a_covered_le_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    covered_q <= needed_q) else $error("covered kinds exceed needed kinds");
  a_needed_le_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    KindW'(plen_q) >= needed_q) else $error("more needed kinds than pattern bytes");
  a_best_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_len_q <= right_q) else $error("best window longer than text");
  a_left_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcw_pkg::StLeftCnt |=> left_q == $past(left_q) + 1'b1)
    else $error("shrink step did not advance left edge");
`endif

endmodule

[rtl/mcw_count_mem.sv]
module mcw_count_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcw_pkg::cnt_req_t   req_i,
  output mcw_pkg::cnt_entry_t rdata_o
);

  mcw_pkg::cnt_entry_t             mem [mcw_pkg::NumSym];
  logic [mcw_pkg::NumSym-1:0]      valid_q;
  mcw_pkg::cnt_entry_t             rdata_q;
  logic                            rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  // entries not written since the last clear read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd) begin
        rvalid_q <= valid_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

[rtl/mcw_text_mem.sv]
module mcw_text_mem (
  input  logic                       clk_i,
  input  logic                       wr_i,
  input  logic [mcw_pkg::TextAw-1:0] waddr_i,
  input  logic [mcw_pkg::SymW-1:0]   wdata_i,
  input  logic                       rd_i,
  input  logic [mcw_pkg::TextAw-1:0] raddr_i,
  output logic [mcw_pkg::SymW-1:0]   rdata_o
);

  logic [mcw_pkg::SymW-1:0] mem [mcw_pkg::MaxText];
  logic [mcw_pkg::SymW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (rd_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[verif/tb_minimum_covering_window_finder_top.sv]
module tb_minimum_covering_window_finder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcw_pkg::*;

  typedef struct packed {
    logic              found;
    logic [TextAw-1:0] start;
    logic [PosW-1:0]   length;
    logic              truncated;
  } report_t;

  typedef struct packed {
    cmd_e            cmd;
    logic [SymW-1:0] sym;
    logic            typed;
    report_t         want;
  } stim_row_t;

  localparam report_t NoReport  = '0;
  localparam int      NumRows   = 25;
  localparam int      OrdTarget = 1600;
  localparam int      CalmFrom  = 1400;
  localparam int      LongHold  = 3000;

  localparam stim_row_t DirectedRows [NumRows] = '{
    '{CmdFinish,  8'h00, 1'b1, '{1'b0, 12'd0, 13'd0, 1'b0}},
    '{CmdClear,   8'hA5, 1'b0, NoReport},
    '{CmdPattern, 8'h00, 1'b0, NoReport},
    '{CmdPattern, 8'hFF, 1'b0, NoReport},
    '{CmdText,    8'hFF, 1'b0, NoReport},
    '{CmdText,    8'h41, 1'b0, NoReport},
    '{CmdText,    8'h00, 1'b0, NoReport},
    '{CmdFinish,  8'h5A, 1'b1, '{1'b1, 12'd0, 13'd3, 1'b0}},
    '{CmdPattern, 8'h41, 1'b0, NoReport},
    '{CmdText,    8'hFF, 1'b0, NoReport},
    '{CmdFinish,  8'hFF, 1'b0, NoReport},
    '{CmdText,    8'h00, 1'b0, NoReport},
    '{CmdFinish,  8'h00, 1'b0, NoReport},
    '{CmdClear,   8'h5A, 1'b0, NoReport},
    '{CmdFinish,  8'h00, 1'b1, '{1'b0, 12'd0, 13'd0, 1'b0}},
    '{CmdText,    8'h55, 1'b0, NoReport},
    '{CmdFinish,  8'h00, 1'b1, '{1'b0, 12'd0, 13'd0, 1'b0}},
    '{CmdClear,   8'h00, 1'b0, NoReport},
    '{CmdPattern, 8'h80, 1'b0, NoReport},
    '{CmdPattern, 8'h80, 1'b0, NoReport},
    '{CmdFinish,  8'h00, 1'b1, '{1'b0, 12'd0, 13'd0, 1'b0}},
    '{CmdText,    8'h80, 1'b0, NoReport},
    '{CmdFinish,  8'h00, 1'b0, NoReport},
    '{CmdText,    8'h80, 1'b0, NoReport},
    '{CmdFinish,  8'h00, 1'b0, NoReport}
  };

  logic clk = 1'b0;
  logic rst_n;

  mcw_in_if  req_if ();
  mcw_out_if rsp_if ();

  minimum_covering_window_finder_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk = ~clk;

  // window tracking state
  logic [NeedW-1:0]  need_tab  [NumSym];
  logic [WinW-1:0]   cover_tab [NumSym];
  logic [SymW-1:0]   text_mem  [MaxText];
  logic [PosW-1:0]   lo_ptr, hi_ptr;
  logic [KindW-1:0]  kinds_met, kinds_req;
  logic [NeedW-1:0]  pat_len;
  logic [TextAw-1:0] best_lo;
  logic [PosW-1:0]   best_len;
  logic              dropped;

  report_t pending_reports [$];
  int      mismatches      = 0;
  int      beats_sent      = 0;
  int      reports_seen    = 0;
  int      sender_idle_pct = 30;
  int      sink_idle_pct   = 30;
  bit      calm            = 1'b0;

  function automatic void track_clear();
    for (int i = 0; i < NumSym; i++) begin
      need_tab[i]  = '0;
      cover_tab[i] = '0;
    end
    lo_ptr    = '0;
    hi_ptr    = '0;
    kinds_met = '0;
    kinds_req = '0;
    pat_len   = '0;
    best_lo   = '0;
    best_len  = '0;
    dropped   = 1'b0;
  endfunction

  function automatic void track_pattern(logic [SymW-1:0] s);
    if (hi_ptr != 0) return;
    if (pat_len >= MaxPattern) begin
      dropped = 1'b1;
      return;
    end
    pat_len++;
    if (need_tab[s] == 0) kinds_req++;
    need_tab[s]++;
  endfunction

  function automatic void track_text(logic [SymW-1:0] s);
    logic [SymW-1:0] c;
    if (hi_ptr >= MaxText) begin
      dropped = 1'b1;
      return;
    end
    text_mem[hi_ptr[TextAw-1:0]] = s;
    hi_ptr++;
    if (need_tab[s] != 0) begin
      cover_tab[s]++;
      if (cover_tab[s] == need_tab[s]) kinds_met++;
    end
    // shrink from the left while every needed byte is still covered
    while (kinds_req != 0 && kinds_met == kinds_req && lo_ptr < hi_ptr) begin
      if (best_len == 0 || (hi_ptr - lo_ptr) < best_len) begin
        best_lo  = lo_ptr[TextAw-1:0];
        best_len = hi_ptr - lo_ptr;
      end
      c = text_mem[lo_ptr[TextAw-1:0]];
      if (need_tab[c] != 0) begin
        cover_tab[c]--;
        if (cover_tab[c] < need_tab[c]) kinds_met--;
      end
      lo_ptr++;
    end
  endfunction

  function automatic report_t track_report();
    report_t r;
    r.found     = (best_len != 0);
    r.start     = r.found ? best_lo : '0;
    r.length    = r.found ? best_len : '0;
    r.truncated = dropped;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(cmd_e c, logic [SymW-1:0] s, logic typed, report_t want);
    report_t r;
    if (!calm && sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.cmd    <= c;
    req_if.symbol <= s;
    do @(posedge clk); while (!req_if.ready);
    beats_sent++;
    case (c)
      CmdClear:   track_clear();
      CmdPattern: track_pattern(s);
      CmdText:    track_text(s);
      CmdFinish: begin
        r = track_report();
        pending_reports.push_back(typed ? want : r);
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_reports_drained();
    req_if.valid <= 1'b0;
    wait (pending_reports.size() == 0);
    @(negedge clk);
  endtask

  task automatic random_job();
    logic [SymW-1:0] alpha [6];
    int n_alpha, plen, tlen, late_at;
    n_alpha = $urandom_range(1, 6);
    foreach (alpha[i]) alpha[i] = SymW'($urandom_range(0, NumSym - 1));
    sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
    // noise
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        send_beat(cmd_e'($urandom_range(0, 3)), SymW'($urandom), 1'b0, NoReport);
      return;
    end
    // sometimes carry the previous job on without a clear
    if ($urandom_range(0, 7) != 0) send_beat(CmdClear, SymW'($urandom), 1'b0, NoReport);
    plen    = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 6);
    tlen    = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 40);
    late_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, tlen) : -1;
    repeat (plen)
      send_beat(CmdPattern, alpha[$urandom_range(0, n_alpha - 1)], 1'b0, NoReport);
    for (int i = 0; i < tlen; i++) begin
      if (i == late_at) send_beat(CmdPattern, alpha[0], 1'b0, NoReport);
      send_beat(CmdText, ($urandom_range(0, 5) == 0) ? SymW'($urandom) :
                alpha[$urandom_range(0, n_alpha - 1)], 1'b0, NoReport);
    end
    send_beat(CmdFinish, SymW'($urandom), 1'b0, NoReport);
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 10))
        send_beat(CmdText, alpha[$urandom_range(0, n_alpha - 1)], 1'b0, NoReport);
      send_beat(CmdFinish, SymW'($urandom), 1'b0, NoReport);
    end
  endtask

  // more pattern bytes than the need table takes
  task automatic crowded_pattern_job();
    logic [SymW-1:0] alpha [3];
    foreach (alpha[i]) alpha[i] = SymW'($urandom);
    send_beat(CmdClear, '0, 1'b0, NoReport);
    repeat (MaxPattern + 2)
      send_beat(CmdPattern, alpha[$urandom_range(0, 2)], 1'b0, NoReport);
    repeat (40) send_beat(CmdText, alpha[$urandom_range(0, 2)], 1'b0, NoReport);
    send_beat(CmdFinish, '0, 1'b0, NoReport);
  endtask

  initial begin : stimulus
    int jobs;
    jobs          = 0;
    rst_n         = 1'b0;
    req_if.valid  = 1'b0;
    req_if.cmd    = CmdClear;
    req_if.symbol = '0;
    track_clear();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (DirectedRows[i])
      send_beat(DirectedRows[i].cmd, DirectedRows[i].sym, DirectedRows[i].typed,
                DirectedRows[i].want);
    wait_reports_drained();
    while (beats_sent < OrdTarget) begin
      if (jobs == 4 || jobs == 24) crowded_pattern_job();
      if (jobs == 16) wait_reports_drained();
      calm = (beats_sent >= CalmFrom);
      random_job();
      jobs++;
    end
    wait_reports_drained();
    repeat (50) @(posedge clk);
    $display("summary: %0d input beats in %0d jobs, %0d reports checked", beats_sent, jobs,
             reports_seen);
    $display("  incl. empty jobs, late pattern bytes, pattern overflow, a long output stall");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : report_sink
    report_t seen, want;
    bit      took;
    bit      held = 1'b0;
    rsp_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      took = rsp_if.valid && rsp_if.ready;
      seen = '{rsp_if.found, rsp_if.window_start, rsp_if.window_length, rsp_if.truncated};
      @(negedge clk);
      if (took) begin
        reports_seen++;
        sink_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
        if (pending_reports.size() == 0) begin
          $error("report beat with nothing pending");
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (seen.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, seen.found);
            mismatches++;
          end
          if (seen.start !== want.start) begin
            $error("window_start: expected %0d, got %0d", want.start, seen.start);
            mismatches++;
          end
          if (seen.length !== want.length) begin
            $error("window_length: expected %0d, got %0d", want.length, seen.length);
            mismatches++;
          end
          if (seen.truncated !== want.truncated) begin
            $error("truncated: expected %0d, got %0d", want.truncated, seen.truncated);
            mismatches++;
          end
        end
      end
      // one long hold-off so the block backs up onto its input
      if (!held && reports_seen >= 15) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end else if (!calm && sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
